// ===== design/rmba_pkg.sv =====
package rmba_pkg;

	localparam int MAX_WIDTH_DEF    = 2048;
	localparam int MAX_HEIGHT_DEF   = 2048;
	localparam int BLK_DIM_DEF      = 16;
	localparam int REGION_COUNT_DEF = 4;
	localparam int REG_SLOTS        = 4;

	localparam int CFG_W     = 45;
	localparam int CFG_IDX_W = 3;
	localparam int DIM_W     = 12;
	localparam int PIX_W     = 11;
	localparam int LUMA_W    = 8;
	localparam int SUM_W     = 16;
	localparam int CNT_W     = 5;
	localparam int BQ_W      = 13;

	localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 12'd1920;
	localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 12'd1080;
	localparam logic [CFG_W-1:0] REGION_ZERO_RST  = 45'd19913481650176;
	localparam logic [CFG_W-1:0] REGION_ONE_RST   = 45'd19913481651616;
	localparam logic [CFG_W-1:0] REGION_TWO_RST   = 45'd3095061545600;
	localparam logic [CFG_W-1:0] REGION_THREE_RST = 45'd2321297264640;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH  = 3'd0,
		CFG_FRAME_HEIGHT = 3'd1,
		CFG_REGION_ZERO  = 3'd2,
		CFG_REGION_ONE   = 3'd3,
		CFG_REGION_TWO   = 3'd4,
		CFG_REGION_THREE = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic              req;
		logic              first;
		logic              masked;
		logic [CNT_W-1:0]  cw;
		logic [CNT_W-1:0]  ch;
		logic [LUMA_W-1:0] luma;
	} entry_ctl_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_ACC,
		BK_DLD,
		BK_DIV,
		BK_EMIT
	} bk_state_t;

endpackage

// ===== design/rmba_front.sv =====
module rmba_front #(
	parameter int MAX_WIDTH    = rmba_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT   = rmba_pkg::MAX_HEIGHT_DEF,
	parameter int BLK_DIM      = rmba_pkg::BLK_DIM_DEF,
	parameter int REGION_COUNT = rmba_pkg::REGION_COUNT_DEF,
	parameter int GRID_COLS    = 128,
	parameter int CELL_W       = 14
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            req,
	input  logic [rmba_pkg::PIX_W-1:0]      px,
	input  logic [rmba_pkg::PIX_W-1:0]      py,
	input  logic [rmba_pkg::LUMA_W-1:0]     luma,
	input  logic [rmba_pkg::DIM_W-1:0]      frame_width,
	input  logic [rmba_pkg::DIM_W-1:0]      frame_height,
	input  logic [rmba_pkg::CFG_W-1:0]      regions [rmba_pkg::REG_SLOTS],
	input  logic                            q_full,
	output logic                            q_push,
	output rmba_pkg::entry_ctl_t            q_ctl,
	output logic [CELL_W-1:0]               q_cell
);

	localparam int BQ    = rmba_pkg::BQ_W;
	localparam int NREG  = (REGION_COUNT < rmba_pkg::REG_SLOTS) ? REGION_COUNT
		: rmba_pkg::REG_SLOTS;
	localparam int RSH   = 24;
	localparam longint RECIP = ((longint'(1) << RSH) + BLK_DIM - 1) / BLK_DIM;
	localparam int PW    = BQ + RSH + 1;

	// floor(v / BLK_DIM) by reciprocal multiply, exact for 13-bit v
	function automatic logic [BQ-1:0] div_blk(input logic [BQ-1:0] v);
		logic [PW-1:0] prod;
		prod = PW'(v) * PW'(RECIP);
		return prod[RSH +: BQ];
	endfunction

	logic                        v_s1, v_s2;
	logic                        req_s1, req_s2;
	logic [rmba_pkg::PIX_W-1:0]  px_s1, py_s1, px_s2, py_s2;
	logic [rmba_pkg::LUMA_W-1:0] luma_s1, luma_s2;
	logic [BQ-1:0]               qx_s2, qy_s2;
	logic                        inside_s2;
	logic [BQ-1:0]               xs_s2 [NREG];
	logic [BQ-1:0]               xe_s2 [NREG];
	logic [BQ-1:0]               ys_s2 [NREG];
	logic [BQ-1:0]               ye_s2 [NREG];
	logic [NREG-1:0]             en_s2;

	logic [BQ-1:0] fw, fh;
	logic          adv1, adv2;

	assign fw = (BQ'(frame_width) < BQ'(MAX_WIDTH)) ? BQ'(frame_width) : BQ'(MAX_WIDTH);
	assign fh = (BQ'(frame_height) < BQ'(MAX_HEIGHT)) ? BQ'(frame_height) : BQ'(MAX_HEIGHT);

	assign adv2     = !v_s2 || (q_push) || !(req_s2 || inside_s2);
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			req_s1  <= req;
			px_s1   <= px;
			py_s1   <= py;
			luma_s1 <= luma;
		end
		if (adv2 && v_s1) begin
			req_s2    <= req_s1;
			px_s2     <= px_s1;
			py_s2     <= py_s1;
			luma_s2   <= luma_s1;
			qx_s2     <= div_blk(BQ'(px_s1));
			qy_s2     <= div_blk(BQ'(py_s1));
			inside_s2 <= (BQ'(px_s1) < fw) && (BQ'(py_s1) < fh);
			for (int i = 0; i < NREG; i++) begin
				xs_s2[i] <= div_blk(BQ'(regions[i][10:0]));
				ys_s2[i] <= div_blk(BQ'(regions[i][21:11]));
				xe_s2[i] <= div_blk(BQ'(regions[i][10:0]) + BQ'(regions[i][32:22])
					+ BQ'(BLK_DIM - 1));
				ye_s2[i] <= div_blk(BQ'(regions[i][21:11]) + BQ'(regions[i][43:33])
					+ BQ'(BLK_DIM - 1));
				en_s2[i] <= regions[i][44];
			end
		end
	end

	logic [BQ-1:0] bx, by, dx, dy;
	logic [25:0]   cell_full;
	logic          covered;

	always_comb begin
		bx        = BQ'(qx_s2 * BQ'(BLK_DIM));
		by        = BQ'(qy_s2 * BQ'(BLK_DIM));
		dx        = fw - bx;
		dy        = fh - by;
		cell_full = 26'(qy_s2) * 26'(GRID_COLS) + 26'(qx_s2);
		covered   = 1'b0;
		for (int i = 0; i < NREG; i++) begin
			if (en_s2[i] && qx_s2 >= xs_s2[i] && qx_s2 < xe_s2[i]
				&& qy_s2 >= ys_s2[i] && qy_s2 < ye_s2[i])
				covered = 1'b1;
		end
		q_ctl.req    = req_s2;
		q_ctl.first  = (BQ'(px_s2) == bx) && (BQ'(py_s2) == by);
		q_ctl.masked = inside_s2 && covered;
		q_ctl.cw     = (dx < BQ'(BLK_DIM)) ? dx[rmba_pkg::CNT_W-1:0]
			: rmba_pkg::CNT_W'(BLK_DIM);
		q_ctl.ch     = (dy < BQ'(BLK_DIM)) ? dy[rmba_pkg::CNT_W-1:0]
			: rmba_pkg::CNT_W'(BLK_DIM);
		q_ctl.luma   = luma_s2;
		q_cell       = cell_full[CELL_W-1:0];
		q_push       = v_s2 && (req_s2 || inside_s2) && !q_full;
	end

endmodule

// ===== design/rmba_fifo.sv =====
module rmba_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         full,
	output logic         empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [PTR_W:0]   cnt_q;

	assign full  = (cnt_q == (PTR_W+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == PTR_W'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (pop)  rp_q <= (rp_q == PTR_W'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= din;
	end

endmodule

// ===== design/rmba_back.sv =====
module rmba_back #(
	parameter int CELLS  = 16384,
	parameter int CELL_W = 14
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  rmba_pkg::entry_ctl_t        q_ctl,
	input  logic [CELL_W-1:0]           q_cell,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [rmba_pkg::LUMA_W-1:0] out_luma,
	output logic                        out_masked
);

	localparam int SW = rmba_pkg::SUM_W;

	rmba_pkg::bk_state_t state_q, state_n;

	logic [SW-1:0]              mem_q [CELLS];
	logic [SW-1:0]              rd_q;
	rmba_pkg::entry_ctl_t       cur_q;
	logic [CELL_W-1:0]          cur_cell_q;
	logic [SW-1:0]              dvd_q;
	logic [7:0]                 rem_q;
	logic [8:0]                 div_q;
	logic [3:0]                 cnt_q;
	logic [rmba_pkg::LUMA_W-1:0] res_luma_q;
	logic                       res_mask_q;
	logic                       out_v_q;
	logic [rmba_pkg::LUMA_W-1:0] out_luma_q;
	logic                       out_mask_q;

	logic              rd_en, wr_en, load_out;
	logic [CELL_W-1:0] wr_addr;
	logic [SW-1:0]     wr_data;
	logic [8:0]        sh;
	logic              ge;

	assign sh = {rem_q, dvd_q[SW-1]};
	assign ge = (sh >= div_q);

	always_comb begin
		state_n  = state_q;
		q_pop    = 1'b0;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = cur_cell_q;
		wr_data  = rd_q + SW'(cur_q.luma);
		load_out = 1'b0;
		unique case (state_q)
			rmba_pkg::BK_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					if (!q_ctl.req) begin
						if (q_ctl.first) begin
							wr_en   = 1'b1;
							wr_addr = q_cell;
							wr_data = SW'(q_ctl.luma);
						end else begin
							rd_en   = 1'b1;
							state_n = rmba_pkg::BK_ACC;
						end
					end else if (q_ctl.masked) begin
						rd_en   = 1'b1;
						state_n = rmba_pkg::BK_DLD;
					end else begin
						state_n = rmba_pkg::BK_EMIT;
					end
				end
			end
			rmba_pkg::BK_ACC: begin
				wr_en   = 1'b1;
				state_n = rmba_pkg::BK_IDLE;
			end
			rmba_pkg::BK_DLD: state_n = rmba_pkg::BK_DIV;
			rmba_pkg::BK_DIV: begin
				if (cnt_q == 4'd15) state_n = rmba_pkg::BK_EMIT;
			end
			rmba_pkg::BK_EMIT: begin
				if (!out_v_q || out_ready) begin
					load_out = 1'b1;
					state_n  = rmba_pkg::BK_IDLE;
				end
			end
			default: state_n = rmba_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rmba_pkg::BK_IDLE;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (load_out)       out_v_q <= 1'b1;
			else if (out_ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem_q[q_cell];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q      <= q_ctl;
			cur_cell_q <= q_cell;
			res_luma_q <= q_ctl.luma;
			res_mask_q <= 1'b0;
		end
		if (state_q == rmba_pkg::BK_DLD) begin
			dvd_q      <= rd_q;
			rem_q      <= '0;
			div_q      <= 9'(cur_q.cw) * 9'(cur_q.ch);
			cnt_q      <= '0;
			res_mask_q <= 1'b1;
		end
		if (state_q == rmba_pkg::BK_DIV) begin
			rem_q <= ge ? 8'(sh - div_q) : sh[7:0];
			dvd_q <= {dvd_q[SW-2:0], ge};
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == 4'd15)
				res_luma_q <= (dvd_q[SW-2:7] != '0) ? 8'd255 : {dvd_q[6:0], ge};
		end
		if (load_out) begin
			out_luma_q <= res_luma_q;
			out_mask_q <= res_mask_q;
		end
	end

	assign out_valid  = out_v_q;
	assign out_luma   = out_luma_q;
	assign out_masked = out_mask_q;

endmodule

// ===== design/region_mosaic_block_average_core.sv =====
// Block-average privacy mosaic over a luma frame.
// Input stream s_axis: one pixel per transfer; tuser carries the pass
// (0 accumulate block sums, 1 apply). Accumulate transfers produce nothing;
// each apply transfer produces exactly one m_axis transfer in order.
// Configuration: cfg_we/cfg_index/cfg_data write frame size and four regions;
// the user must write only while no pixel is in flight, as the block does not enforce it.
// Structure: a two-stage front (block index, region extents, coverage) feeds
// a four-entry queue; the back end owns the block-sum memory. A result passes
// both front stages and the queue, then IDLE and EMIT (pass-through) or IDLE,
// DLD, DIV and EMIT (masked) in the back end, into the output register.
// Back-end work per item: a block's first accumulate is one memory write in
// IDLE; other accumulates read then write memory (IDLE, ACC); a pass-through
// apply goes IDLE then EMIT; a masked apply adds DLD and the 16-step serial
// divide in DIV by the edge-clipped pixel count. Out-of-frame accumulates
// are dropped in the front. No new entry is popped until the back end is in IDLE.
// Reset: control state clears, config returns to defaults; block sums are
// undefined until accumulated.
// A stalled m_tready holds the output register; the back end then waits and
// the queue and both front stages take up to six more items before s_tready drops.
module region_mosaic_block_average_core #(
	parameter int MAX_WIDTH    = rmba_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT   = rmba_pkg::MAX_HEIGHT_DEF,
	parameter int BLK_DIM      = rmba_pkg::BLK_DIM_DEF,
	parameter int REGION_COUNT = rmba_pkg::REGION_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [31:0]                       s_tdata,  // pix_x, pix_y, luma_in
	input  logic                              s_tuser,  // req_type
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [15:0]                       m_tdata,  // luma_out, was_masked
	input  logic                              cfg_we,
	input  logic [rmba_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rmba_pkg::CFG_W-1:0]        cfg_data
);

	localparam int GRID_COLS = (MAX_WIDTH + BLK_DIM - 1) / BLK_DIM;
	localparam int GRID_ROWS = (MAX_HEIGHT + BLK_DIM - 1) / BLK_DIM;
	localparam int CELLS     = GRID_COLS * GRID_ROWS;
	localparam int CELL_W    = $clog2(CELLS);
	localparam int QW        = $bits(rmba_pkg::entry_ctl_t) + CELL_W;

	logic [rmba_pkg::DIM_W-1:0] frame_width_q, frame_height_q;
	logic [rmba_pkg::CFG_W-1:0] region_q [rmba_pkg::REG_SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= rmba_pkg::FRAME_WIDTH_RST;
			frame_height_q <= rmba_pkg::FRAME_HEIGHT_RST;
			region_q[0]    <= rmba_pkg::REGION_ZERO_RST;
			region_q[1]    <= rmba_pkg::REGION_ONE_RST;
			region_q[2]    <= rmba_pkg::REGION_TWO_RST;
			region_q[3]    <= rmba_pkg::REGION_THREE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rmba_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data[11:0];
				rmba_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data[11:0];
				rmba_pkg::CFG_REGION_ZERO:  region_q[0]    <= cfg_data;
				rmba_pkg::CFG_REGION_ONE:   region_q[1]    <= cfg_data;
				rmba_pkg::CFG_REGION_TWO:   region_q[2]    <= cfg_data;
				rmba_pkg::CFG_REGION_THREE: region_q[3]    <= cfg_data;
				default: ;
			endcase
		end
	end

	logic                 q_full, q_empty, q_push, q_pop;
	rmba_pkg::entry_ctl_t f_ctl, b_ctl;
	logic [CELL_W-1:0]    f_cell, b_cell;
	logic [QW-1:0]        q_dout;
	logic [7:0]           out_luma;
	logic                 out_masked;

	rmba_front #(
		.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .BLK_DIM(BLK_DIM),
		.REGION_COUNT(REGION_COUNT), .GRID_COLS(GRID_COLS), .CELL_W(CELL_W)
	) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.req(s_tuser), .px(s_tdata[10:0]), .py(s_tdata[21:11]), .luma(s_tdata[29:22]),
		.frame_width(frame_width_q), .frame_height(frame_height_q), .regions(region_q),
		.q_full(q_full), .q_push(q_push), .q_ctl(f_ctl), .q_cell(f_cell)
	);

	rmba_fifo #(.W(QW), .DEPTH(4)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(q_push), .din({f_ctl, f_cell}),
		.pop(q_pop), .dout(q_dout),
		.full(q_full), .empty(q_empty)
	);

	assign b_ctl  = q_dout[QW-1:CELL_W];
	assign b_cell = q_dout[CELL_W-1:0];

	rmba_back #(.CELLS(CELLS), .CELL_W(CELL_W)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_empty(q_empty), .q_ctl(b_ctl), .q_cell(b_cell), .q_pop(q_pop),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_luma(out_luma), .out_masked(out_masked)
	);

	assign m_tdata = {7'd0, out_masked, out_luma};

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BS        = rmba_pkg::BLK_DIM_DEF;
	localparam int MAXW      = rmba_pkg::MAX_WIDTH_DEF;
	localparam int MAXH      = rmba_pkg::MAX_HEIGHT_DEF;
	localparam int NSLOT     = rmba_pkg::REG_SLOTS;
	localparam int CW        = rmba_pkg::CFG_W;
	localparam int GCOLS     = (MAXW + BS - 1) / BS;
	localparam int GCELLS    = GCOLS * ((MAXH + BS - 1) / BS);
	localparam int IDLE_PCT  = 34;
	localparam int STALL_LIM = 20000;

	typedef struct {
		bit        req;
		bit [10:0] x;
		bit [10:0] y;
		bit [7:0]  luma;
	} pixel_t;

	typedef struct {
		bit [7:0] luma;
		bit       masked;
	} mosaic_res_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [31:0]       s_tdata = '0;   // pix_x, pix_y, luma_in
	logic              s_tuser = 1'b0; // req_type
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [15:0]       m_tdata;        // luma_out, was_masked
	logic              cfg_we = 1'b0;
	logic [rmba_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [CW-1:0]     cfg_data = '0;

	region_mosaic_block_average_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	pixel_t      pix_q[$];
	mosaic_res_t mosaic_q[$];
	pixel_t      drv_pix;
	int          err_cnt = 0;
	int          cyc = 0;
	int          stall_cnt = 0;
	int          n_out = 0;
	int          hold_cnt = 0;
	bit          held = 0;
	int          n_items = 0;

	bit [11:0]   fw_reg, fh_reg;
	bit [CW-1:0] region_reg[NSLOT];
	bit [15:0]   block_sum[GCELLS];
	bit          block_seen[GCELLS];

	function automatic bit no_idle();
		return cyc >= 3000 && cyc < 7000;
	endfunction

	function automatic int eff_w();
		return fw_reg > MAXW ? MAXW : fw_reg;
	endfunction

	function automatic int eff_h();
		return fh_reg > MAXH ? MAXH : fh_reg;
	endfunction

	function automatic bit block_in_region(int bx, int by);
		int rx, ry, rw, rh;
		for (int i = 0; i < rmba_pkg::REGION_COUNT_DEF && i < NSLOT; i++) begin
			rx = region_reg[i][10:0];
			ry = region_reg[i][21:11];
			rw = region_reg[i][32:22];
			rh = region_reg[i][43:33];
			if (region_reg[i][44] && bx >= rx / BS * BS && bx < (rx + rw + BS - 1) / BS * BS
			    && by >= ry / BS * BS && by < (ry + rh + BS - 1) / BS * BS)
				return 1;
		end
		return 0;
	endfunction

	// Predicts and queues one pixel; requests that would touch a block sum
	// never written since reset are turned into that block's top-left accumulate.
	task automatic send_pixel(bit req, int px, int py, int luma);
		pixel_t      p;
		mosaic_res_t r;
		int          bx, by, blk_idx, cw, ch, avg;
		bit          in_frame;
		in_frame = px < eff_w() && py < eff_h();
		bx = px / BS * BS;
		by = py / BS * BS;
		blk_idx = (py / BS) * GCOLS + px / BS;
		if (in_frame && !block_seen[blk_idx] && (px != bx || py != by || req)
		    && (!req || block_in_region(bx, by))) begin
			req = 0;
			px = bx;
			py = by;
		end
		p.req = req; p.x = 11'(px); p.y = 11'(py); p.luma = 8'(luma);
		pix_q.push_back(p);
		n_items++;
		if (!req) begin
			if (in_frame) begin
				block_sum[blk_idx] = (px == bx && py == by) ? 16'(luma)
					: block_sum[blk_idx] + 16'(luma);
				block_seen[blk_idx] = 1;
			end
		end else if (in_frame && block_in_region(bx, by)) begin
			cw = eff_w() - bx < BS ? eff_w() - bx : BS;
			ch = eff_h() - by < BS ? eff_h() - by : BS;
			avg = block_sum[blk_idx] / (cw * ch);
			r.luma = avg > 255 ? 8'd255 : 8'(avg);
			r.masked = 1;
			mosaic_q.push_back(r);
		end else begin
			r.luma = 8'(luma);
			r.masked = 0;
			mosaic_q.push_back(r);
		end
	endtask

	task automatic write_reg(int idx, bit [CW-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= rmba_pkg::CFG_IDX_W'(idx);
		cfg_data <= val;
		if (idx == rmba_pkg::CFG_FRAME_WIDTH) fw_reg = val[11:0];
		else if (idx == rmba_pkg::CFG_FRAME_HEIGHT) fh_reg = val[11:0];
		else if (idx >= rmba_pkg::CFG_REGION_ZERO && idx <= rmba_pkg::CFG_REGION_THREE)
			region_reg[idx - rmba_pkg::CFG_REGION_ZERO] = val;
	endtask

	task automatic wait_idle();
		while (pix_q.size() != 0 || s_tvalid || mosaic_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic bit [CW-1:0] rand_region();
		bit [10:0] x, y, w, h;
		x = $urandom_range(0, 99) < 70 ? 11'($urandom_range(0, 48)) : 11'($urandom);
		y = $urandom_range(0, 99) < 70 ? 11'($urandom_range(0, 48)) : 11'($urandom);
		w = $urandom_range(0, 99) < 80 ? 11'($urandom_range(0, 40)) : 11'($urandom);
		h = $urandom_range(0, 99) < 80 ? 11'($urandom_range(0, 40)) : 11'($urandom);
		if ($urandom_range(0, 9) == 0) begin
			x = 11'(x / BS * BS);
			w = 0;
		end
		return {1'($urandom_range(0, 99) < 75), h, w, y, x};
	endfunction

	task automatic configure(int w, int h);
		write_reg(rmba_pkg::CFG_FRAME_WIDTH, CW'(w));
		write_reg(rmba_pkg::CFG_FRAME_HEIGHT, CW'(h));
		for (int i = 0; i < NSLOT; i++)
			write_reg(rmba_pkg::CFG_REGION_ZERO + i, rand_region());
		if ($urandom_range(0, 3) == 0)
			write_reg($urandom_range(6, 7), CW'({$urandom, $urandom}));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_noise();
		send_pixel($urandom_range(0, 1), 11'($urandom), 11'($urandom), 8'($urandom));
	endtask

	task automatic raster(bit req, int x0, int y0, int x1, int y1);
		for (int y = y0; y < y1; y++)
			for (int x = x0; x < x1; x++) begin
				if ($urandom_range(0, 9) == 0) send_noise();
				send_pixel(req, x, y, $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 255 : 0)
				                                               : $urandom_range(0, 255));
			end
	endtask

	initial begin
		int kind, w, h, bx, by;
		fw_reg = rmba_pkg::FRAME_WIDTH_RST;
		fh_reg = rmba_pkg::FRAME_HEIGHT_RST;
		region_reg[0] = rmba_pkg::REGION_ZERO_RST;
		region_reg[1] = rmba_pkg::REGION_ONE_RST;
		region_reg[2] = rmba_pkg::REGION_TWO_RST;
		region_reg[3] = rmba_pkg::REGION_THREE_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset configuration, out-of-frame pixels
		send_pixel(0, 0, 0, 0);
		send_pixel(1, 0, 0, 0);
		send_pixel(0, 2047, 0, 255);
		send_pixel(1, 2047, 2047, 255);
		send_pixel(1, 1919, 1079, 128);
		wait_idle();
		// single-pixel frame
		write_reg(rmba_pkg::CFG_FRAME_WIDTH, 1);
		write_reg(rmba_pkg::CFG_FRAME_HEIGHT, 1);
		write_reg(rmba_pkg::CFG_REGION_ZERO, {1'b1, 11'd1, 11'd1, 11'd0, 11'd0});
		write_reg(rmba_pkg::CFG_REGION_ONE, {1'b1, 11'd0, 11'd0, 11'd16, 11'd16});
		write_reg(rmba_pkg::CFG_REGION_TWO, '0);
		write_reg(rmba_pkg::CFG_REGION_THREE, '1);
		@(posedge clk);
		cfg_we <= 1'b0;
		send_pixel(0, 0, 0, 200);
		send_pixel(0, 0, 0, 200);
		send_pixel(1, 0, 0, 7);
		send_pixel(1, 1, 0, 9);
		send_pixel(1, 0, 1, 9);
		wait_idle();
		// empty frame
		write_reg(rmba_pkg::CFG_FRAME_WIDTH, 0);
		write_reg(rmba_pkg::CFG_FRAME_HEIGHT, 0);
		@(posedge clk);
		cfg_we <= 1'b0;
		send_pixel(0, 0, 0, 1);
		send_pixel(1, 0, 0, 3);
		wait_idle();

		n_items = 0;
		while (n_items < 1650) begin
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				w = $urandom_range(1, 40);
				h = $urandom_range(1, 160 / w > 1 ? 160 / w : 1);
				configure(w, h);
				raster(0, 0, 0, w, h);
				raster(1, 0, 0, w, h);
			end else if (kind < 9) begin
				case ($urandom_range(0, 3))
					0: w = 2048;
					1: w = 4095;
					2: w = 2040;
					default: w = $urandom_range(1, 4095);
				endcase
				h = $urandom_range(0, 1) ? $urandom_range(1, 4095) : ($urandom_range(0, 1) ? 2048 : 2041);
				configure(w, h);
				bx = (eff_w() - 1) / BS * BS;
				by = (eff_h() - 1) / BS * BS;
				write_reg(rmba_pkg::CFG_REGION_ZERO, {1'b1, 11'd16, 11'd16, 11'(by), 11'(bx)});
				@(posedge clk);
				cfg_we <= 1'b0;
				raster(0, bx, by, eff_w(), eff_h());
				raster(1, bx, by, eff_w(), eff_h());
			end else begin
				w = $urandom_range(1, 4);
				h = $urandom_range(1, 4);
				configure(w, h);
				write_reg(rmba_pkg::CFG_REGION_ZERO, {1'b1, 11'd4, 11'd4, 11'd0, 11'd0});
				@(posedge clk);
				cfg_we <= 1'b0;
				raster(0, 0, 0, w, h);
				// repeated pixel drives the sum to saturation and wrap
				repeat ($urandom_range(20, 300)) send_pixel(0, w - 1, h - 1, 255);
				raster(1, 0, 0, w, h);
			end
			wait_idle();
		end

		wait_idle();
		repeat (100) @(posedge clk);
		if (err_cnt == 0)
			$display("region_mosaic_block_average_core: match");
		else
			$display("region_mosaic_block_average_core: mismatch");
		$finish;
	end

	always @(posedge clk) begin
		if (!s_tvalid || s_tready) begin
			if (pix_q.size() != 0 && (no_idle() || $urandom_range(0, 99) >= IDLE_PCT)) begin
				drv_pix = pix_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {2'b00, drv_pix.luma, drv_pix.y, drv_pix.x};
				s_tuser <= drv_pix.req;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!held && n_out >= 150 && pix_q.size() >= 40) begin
			held <= 1;
			hold_cnt <= 400;
			m_tready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= no_idle() || $urandom_range(0, 99) >= IDLE_PCT;
		end
	end

	always @(posedge clk) begin
		mosaic_res_t e;
		cyc <= cyc + 1;
		if (m_tvalid && m_tready) begin
			n_out <= n_out + 1;
			if (mosaic_q.size() == 0) begin
				$error("unexpected transfer: luma_out %0d was_masked %0d", m_tdata[7:0], m_tdata[8]);
				err_cnt++;
			end else begin
				e = mosaic_q.pop_front();
				if (m_tdata[7:0] !== e.luma) begin
					$error("luma_out expected %0d actual %0d", e.luma, m_tdata[7:0]);
					err_cnt++;
				end
				if (m_tdata[8] !== e.masked) begin
					$error("was_masked expected %0d actual %0d", e.masked, m_tdata[8]);
					err_cnt++;
				end
			end
		end
		if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
			stall_cnt <= 0;
		end else if (stall_cnt >= STALL_LIM) begin
			$display("region_mosaic_block_average_core: mismatch");
			$finish;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
	end
endmodule

// ===== filelist.f =====
design/rmba_pkg.sv
design/rmba_front.sv
design/rmba_fifo.sv
design/rmba_back.sv
design/region_mosaic_block_average_core.sv
tb/tb_top.sv
